// File: rtl/core/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Shared constants, types and helpers of the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;

	// operation codes
	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_DIV  = 3'd3;
	localparam logic [2:0] CMD_SQRT = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam int NLO_W     = DW - FRAC_BITS;
	localparam int DIV_QW    = DW + 1;
	localparam int DIV_STEPS = DIV_QW;
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int SQ_STEPS  = 32;
	localparam int SQRT_LAT  = 2 * SQ_STEPS + 2;
	localparam int PAD_LAT   = SQRT_LAT - DIV_LAT;

	localparam logic [64:0] HALF     = 65'd1 << (FRAC_BITS - 1);
	localparam logic [63:0] HUGE_MAG = 64'd1 << 40;
	localparam logic [63:0] POS_MAX  = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_MAG  = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [31:0] val;
		logic        ovf;
	} sat_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        eq;
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        neg_re;
		logic        neg_im;
		logic        dzero;
		logic        ai_neg;
	} side_t;

	// sign and magnitude to saturated 32-bit value
	function automatic sat_t sat_sm(logic neg, logic [63:0] mag);
		sat_t o;
		o.ovf = 1'b0;
		if (neg) begin
			if (mag > NEG_MAG) begin
				o.ovf = 1'b1;
				o.val = 32'h8000_0000;
			end else begin
				o.val = 32'd0 - mag[31:0];
			end
		end else begin
			if (mag > POS_MAX) begin
				o.ovf = 1'b1;
				o.val = 32'h7FFF_FFFF;
			end else begin
				o.val = mag[31:0];
			end
		end
		return o;
	endfunction

	function automatic sat_t sat_s33(logic [32:0] v);
		sat_t o;
		o.ovf = v[32] != v[31];
		if (o.ovf) o.val = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else o.val = v[31:0];
		return o;
	endfunction

	// one step of the digit-by-digit integer root
	function automatic sq_t sq_step(sq_t s, logic [63:0] b);
		sq_t o;
		logic [63:0] t;
		t = s.r + b;
		if (s.v >= t) begin
			o.v = s.v - t;
			o.r = (s.r >> 1) + b;
		end else begin
			o.v = s.v;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

endpackage

// File: rtl/core/cau_front.sv
// ---------------------------------------------------------------------------
// cau_front
// Operand capture, products, wide sums, sign and magnitude, add, subtract
// and multiply results; five register stages.
// ---------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               out_valid,
	output side_t              side,
	output logic [63:0]        n_re,
	output logic [63:0]        n_im,
	output logic [63:0]        mag2,
	output logic [31:0]        root_re
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [2:0]         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	logic               eq_s2, eq_s3, eq_s4;
	sat_t               as_re_s2, as_im_s2, as_re_s3, as_im_s3, as_re_s4, as_im_s4;
	logic signed [63:0] prr_s2, pii_s2, pri_s2, pir_s2, pxx_s2, pyy_s2;
	logic [31:0]        ar_s2, ar_s3, ar_s4, ar_s5;
	logic               ai_neg_s2, ai_neg_s3, ai_neg_s4;

	logic [64:0] re_s3, im_s3;
	logic [63:0] mag2_s3;

	logic        neg_re_s4, neg_im_s4, dzero_s4;
	logic [63:0] mag_re_s4, mag_im_s4, mag2_s4;

	side_t       side_s5;
	logic [63:0] n_re_s5, n_im_s5, mag2_s5;

	logic signed [31:0] sq_x, sq_y;
	logic signed [32:0] sum_re, sum_im;
	logic [64:0]        lane_re, lane_im;
	sat_t               mul_re, mul_im;

	// sign and magnitude; rounded half away from zero for the multiply
	function automatic logic [64:0] lane_mag(logic [64:0] v, logic rnd);
		logic [64:0] abs_v, rnd_v;
		abs_v = v[64] ? (65'd0 - v) : v;
		rnd_v = v[64] ? (~v + HALF + 65'd1) : (v + HALF);
		return {v[64], rnd ? rnd_v[63:0] : abs_v[63:0]};
	endfunction

	always_comb begin
		sq_x   = (cmd_s1 == CMD_SQRT) ? ar_s1 : br_s1;
		sq_y   = (cmd_s1 == CMD_SQRT) ? ai_s1 : bi_s1;
		sum_re = (cmd_s1 == CMD_SUB) ? (33'(ar_s1) - 33'(br_s1)) : (33'(ar_s1) + 33'(br_s1));
		sum_im = (cmd_s1 == CMD_SUB) ? (33'(ai_s1) - 33'(bi_s1)) : (33'(ai_s1) + 33'(bi_s1));
		lane_re = lane_mag(re_s3, cmd_s3 == CMD_MUL);
		lane_im = lane_mag(im_s3, cmd_s3 == CMD_MUL);
		mul_re  = sat_sm(neg_re_s4, mag_re_s4 >> FRAC_BITS);
		mul_im  = sat_sm(neg_im_s4, mag_im_s4 >> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1: operand capture
		cmd_s1 <= cmd;
		ar_s1  <= a_re;
		ai_s1  <= a_im;
		br_s1  <= b_re;
		bi_s1  <= b_im;

		// s2: products, add and subtract
		cmd_s2    <= cmd_s1;
		eq_s2     <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		as_re_s2  <= sat_s33(sum_re);
		as_im_s2  <= sat_s33(sum_im);
		prr_s2    <= ar_s1 * br_s1;
		pii_s2    <= ai_s1 * bi_s1;
		pri_s2    <= ar_s1 * bi_s1;
		pir_s2    <= ai_s1 * br_s1;
		pxx_s2    <= sq_x * sq_x;
		pyy_s2    <= sq_y * sq_y;
		ar_s2     <= ar_s1;
		ai_neg_s2 <= ai_s1[31];

		// s3: wide sums
		cmd_s3    <= cmd_s2;
		eq_s3     <= eq_s2;
		as_re_s3  <= as_re_s2;
		as_im_s3  <= as_im_s2;
		re_s3     <= (cmd_s2 == CMD_DIV) ? (65'(prr_s2) + 65'(pii_s2))
			: (65'(prr_s2) - 65'(pii_s2));
		im_s3     <= (cmd_s2 == CMD_DIV) ? (65'(pir_s2) - 65'(pri_s2))
			: (65'(pri_s2) + 65'(pir_s2));
		mag2_s3   <= $unsigned(pxx_s2) + $unsigned(pyy_s2);
		ar_s3     <= ar_s2;
		ai_neg_s3 <= ai_neg_s2;

		// s4: sign and magnitude
		cmd_s4    <= cmd_s3;
		eq_s4     <= eq_s3;
		as_re_s4  <= as_re_s3;
		as_im_s4  <= as_im_s3;
		neg_re_s4 <= lane_re[64];
		mag_re_s4 <= lane_re[63:0];
		neg_im_s4 <= lane_im[64];
		mag_im_s4 <= lane_im[63:0];
		mag2_s4   <= mag2_s3;
		dzero_s4  <= mag2_s3 == 64'd0;
		ar_s4     <= ar_s3;
		ai_neg_s4 <= ai_neg_s3;

		// s5: multiply saturation, merge of the simple results
		side_s5.cmd    <= cmd_s4;
		side_s5.eq     <= eq_s4;
		side_s5.re     <= (cmd_s4 == CMD_MUL) ? mul_re.val : as_re_s4.val;
		side_s5.im     <= (cmd_s4 == CMD_MUL) ? mul_im.val : as_im_s4.val;
		side_s5.ovf    <= (cmd_s4 == CMD_MUL) ? (mul_re.ovf | mul_im.ovf)
			: (as_re_s4.ovf | as_im_s4.ovf);
		side_s5.neg_re <= neg_re_s4;
		side_s5.neg_im <= neg_im_s4;
		side_s5.dzero  <= dzero_s4;
		side_s5.ai_neg <= ai_neg_s4;
		n_re_s5        <= mag_re_s4;
		n_im_s5        <= mag_im_s4;
		mag2_s5        <= mag2_s4;
		ar_s5          <= ar_s4;
	end

	assign out_valid = v_s5;
	assign side      = side_s5;
	assign n_re      = n_re_s5;
	assign n_im      = n_im_s5;
	assign mag2      = mag2_s5;
	assign root_re   = ar_s5;

endmodule

// File: rtl/core/cau_div.sv
// ---------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, two lanes sharing one divisor; one quotient
// bit per stage plus an entry stage with the range check.
// ---------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
	input  logic              clk,
	input  logic [63:0]       n_re,
	input  logic [63:0]       n_im,
	input  logic [63:0]       d,
	output logic [DIV_QW-1:0] q_re,
	output logic [DIV_QW-1:0] q_im,
	output logic              huge_re,
	output logic              huge_im
);

	logic [63:0]       d_s      [DIV_STEPS+1];
	logic [63:0]       rem_re_s [DIV_STEPS+1];
	logic [63:0]       rem_im_s [DIV_STEPS+1];
	logic [NLO_W-1:0]  nlo_re_s [DIV_STEPS+1];
	logic [NLO_W-1:0]  nlo_im_s [DIV_STEPS+1];
	logic [DIV_QW-1:0] q_re_s   [DIV_STEPS+1];
	logic [DIV_QW-1:0] q_im_s   [DIV_STEPS+1];
	logic              huge_re_s[DIV_STEPS+1];
	logic              huge_im_s[DIV_STEPS+1];

	function automatic logic [64:0] div_step(logic [63:0] r, logic b, logic [63:0] dv);
		logic [64:0] t;
		t = {r, b};
		if (t >= {1'b0, dv}) return {1'b1, 64'(t - {1'b0, dv})};
		return {1'b0, t[63:0]};
	endfunction

	always_ff @(posedge clk) begin
		d_s[0]       <= d;
		rem_re_s[0]  <= n_re >> NLO_W;
		rem_im_s[0]  <= n_im >> NLO_W;
		huge_re_s[0] <= (n_re >> NLO_W) >= d;
		huge_im_s[0] <= (n_im >> NLO_W) >= d;
		nlo_re_s[0]  <= n_re[NLO_W-1:0];
		nlo_im_s[0]  <= n_im[NLO_W-1:0];
		q_re_s[0]    <= '0;
		q_im_s[0]    <= '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			logic [64:0] st_re, st_im;
			st_re = div_step(rem_re_s[i], nlo_re_s[i][NLO_W-1], d_s[i]);
			st_im = div_step(rem_im_s[i], nlo_im_s[i][NLO_W-1], d_s[i]);
			d_s[i+1]       <= d_s[i];
			rem_re_s[i+1]  <= st_re[63:0];
			rem_im_s[i+1]  <= st_im[63:0];
			q_re_s[i+1]    <= {q_re_s[i][DIV_QW-2:0], st_re[64]};
			q_im_s[i+1]    <= {q_im_s[i][DIV_QW-2:0], st_im[64]};
			nlo_re_s[i+1]  <= nlo_re_s[i] << 1;
			nlo_im_s[i+1]  <= nlo_im_s[i] << 1;
			huge_re_s[i+1] <= huge_re_s[i];
			huge_im_s[i+1] <= huge_im_s[i];
		end
	end

	assign q_re    = q_re_s[DIV_STEPS];
	assign q_im    = q_im_s[DIV_STEPS];
	assign huge_re = huge_re_s[DIV_STEPS];
	assign huge_im = huge_im_s[DIV_STEPS];

endmodule

// File: rtl/core/cau_sqrt.sv
// ---------------------------------------------------------------------------
// cau_sqrt
// Pipelined principal root: modulus root, half-sum stage, then two root
// lanes for the real and imaginary magnitudes; one digit per stage.
// ---------------------------------------------------------------------------
module cau_sqrt import cau_pkg::*; (
	input  logic        clk,
	input  logic [63:0] mag2,
	input  logic [31:0] root_re,
	output logic [31:0] s_re,
	output logic [31:0] s_im
);

	sq_t         mod_s  [SQ_STEPS+1];
	logic [31:0] ar_s   [SQ_STEPS+1];
	sq_t         up_s   [SQ_STEPS+1];
	sq_t         dn_s   [SQ_STEPS+1];

	logic [63:0] ar_ext, up_v, dn_v;

	always_comb begin
		ar_ext = {{32{ar_s[SQ_STEPS][31]}}, ar_s[SQ_STEPS]};
		up_v   = (mod_s[SQ_STEPS].r + ar_ext) << (FRAC_BITS - 1);
		dn_v   = (mod_s[SQ_STEPS].r - ar_ext) << (FRAC_BITS - 1);
	end

	always_ff @(posedge clk) begin
		mod_s[0] <= '{v: mag2, r: 64'd0};
		ar_s[0]  <= root_re;
		up_s[0]  <= '{v: up_v, r: 64'd0};
		dn_s[0]  <= '{v: dn_v, r: 64'd0};
		for (int i = 0; i < SQ_STEPS; i++) begin
			mod_s[i+1] <= sq_step(mod_s[i], 64'd1 << (62 - 2 * i));
			ar_s[i+1]  <= ar_s[i];
			up_s[i+1]  <= sq_step(up_s[i], 64'd1 << (62 - 2 * i));
			dn_s[i+1]  <= sq_step(dn_s[i], 64'd1 << (62 - 2 * i));
		end
	end

	assign s_re = up_s[SQ_STEPS].r[31:0];
	assign s_im = dn_s[SQ_STEPS].r[31:0];

endmodule

// File: rtl/core/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and principal root on signed
// Q16.16 operands, fully pipelined.
//
//   channel   handshake        beat contents
//   input     start / busy     cmd, a_re, a_im, b_re, b_im
//   result    done (strobe)    res_re, res_im, status, operands_equal
//
// One beat may enter every cycle; busy is always low.
// Every operation takes the same path length, set by the root path: five
// front stages, 66 root stages and the output register.
// Reset clears the valid bits only, dropping any beat in flight; otherwise no beat is lost or repeated.
// The result receiver cannot stall; done is high for one cycle per beat.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic [1:0]         status,
	output logic               operands_equal
);

	logic        fr_valid;
	side_t       fr_side;
	logic [63:0] fr_n_re, fr_n_im, fr_mag2;
	logic [31:0] fr_root_re;

	logic [DIV_QW-1:0] dq_re, dq_im;
	logic              dh_re, dh_im;
	logic [31:0]       sq_re, sq_im;

	logic  side_v_s [SQRT_LAT];
	side_t side_s   [SQRT_LAT];

	logic [DIV_QW-1:0] pq_re_s [PAD_LAT];
	logic [DIV_QW-1:0] pq_im_s [PAD_LAT];
	logic              ph_re_s [PAD_LAT];
	logic              ph_im_s [PAD_LAT];

	logic        done_q, eq_q;
	logic [31:0] re_q, im_q;
	logic [1:0]  st_q;

	side_t       sd;
	sat_t        f_re, f_im;
	logic [63:0] dm_re, dm_im;
	logic [1:0]  f_st;

	assign busy = 1'b0;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.cmd      (cmd),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.out_valid(fr_valid),
		.side     (fr_side),
		.n_re     (fr_n_re),
		.n_im     (fr_n_im),
		.mag2     (fr_mag2),
		.root_re  (fr_root_re)
	);

	cau_div u_div (
		.clk    (clk),
		.n_re   (fr_n_re),
		.n_im   (fr_n_im),
		.d      (fr_mag2),
		.q_re   (dq_re),
		.q_im   (dq_im),
		.huge_re(dh_re),
		.huge_im(dh_im)
	);

	cau_sqrt u_sqrt (
		.clk    (clk),
		.mag2   (fr_mag2),
		.root_re(fr_root_re),
		.s_re   (sq_re),
		.s_im   (sq_im)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQRT_LAT; i++) side_v_s[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			side_v_s[0] <= fr_valid;
			for (int i = 1; i < SQRT_LAT; i++) side_v_s[i] <= side_v_s[i-1];
			done_q <= side_v_s[SQRT_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0]  <= fr_side;
		pq_re_s[0] <= dq_re;
		pq_im_s[0] <= dq_im;
		ph_re_s[0] <= dh_re;
		ph_im_s[0] <= dh_im;
		for (int i = 1; i < SQRT_LAT; i++) side_s[i] <= side_s[i-1];
		for (int i = 1; i < PAD_LAT; i++) begin
			pq_re_s[i] <= pq_re_s[i-1];
			pq_im_s[i] <= pq_im_s[i-1];
			ph_re_s[i] <= ph_re_s[i-1];
			ph_im_s[i] <= ph_im_s[i-1];
		end
	end

	// final selection, divide rounding and saturation
	always_comb begin
		sd    = side_s[SQRT_LAT-1];
		dm_re = ph_re_s[PAD_LAT-1] ? HUGE_MAG
			: 64'(({1'b0, pq_re_s[PAD_LAT-1]} + (DIV_QW+1)'(1)) >> 1);
		dm_im = ph_im_s[PAD_LAT-1] ? HUGE_MAG
			: 64'(({1'b0, pq_im_s[PAD_LAT-1]} + (DIV_QW+1)'(1)) >> 1);
		f_re  = '{val: 32'd0, ovf: 1'b0};
		f_im  = '{val: 32'd0, ovf: 1'b0};
		f_st  = ST_OK;
		case (sd.cmd)
			CMD_ADD, CMD_SUB, CMD_MUL: begin
				f_re = '{val: sd.re, ovf: sd.ovf};
				f_im = '{val: sd.im, ovf: 1'b0};
			end
			CMD_DIV: begin
				if (!sd.dzero) begin
					f_re = sat_sm(sd.neg_re, dm_re);
					f_im = sat_sm(sd.neg_im, dm_im);
				end
			end
			CMD_SQRT: begin
				f_re = sat_sm(1'b0, {32'd0, sq_re});
				f_im = sat_sm(sd.ai_neg, {32'd0, sq_im});
			end
			default: begin
				f_re = '{val: 32'd0, ovf: 1'b0};
				f_im = '{val: 32'd0, ovf: 1'b0};
			end
		endcase
		if (sd.cmd == CMD_DIV && sd.dzero) f_st = ST_DIVZ;
		else if (f_re.ovf | f_im.ovf) f_st = ST_SAT;
	end

	always_ff @(posedge clk) begin
		re_q <= f_re.val;
		im_q <= f_im.val;
		st_q <= f_st;
		eq_q <= sd.eq;
	end

	assign done           = done_q;
	assign res_re         = re_q;
	assign res_im         = im_q;
	assign status         = st_q;
	assign operands_equal = eq_q;

endmodule

// File: tb/tb_complex_arithmetic_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench for the complex arithmetic unit: directed corner beats
// and random operand pairs over every operation code, random input gaps,
// each result beat compared against a fixed-point golden calculation.
// ---------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] ar, ai, br, bi;
	} op_beat_t;

	typedef struct {
		logic [31:0] re, im;
		logic [1:0]  st;
		logic        eq;
	} cplx_res_t;

	logic clk, arst_n, start, busy, done, operands_equal;
	logic [2:0] cmd;
	logic signed [31:0] a_re, a_im, b_re, b_im, res_re, res_im;
	logic [1:0] status;

	op_beat_t  pending_ops[$];
	cplx_res_t expected_res[$];
	int errors = 0, n_sent = 0, n_checked = 0, gap = 0;

	complex_arithmetic_unit u_top (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic logic [31:0] clamp_mag(logic neg, logic [63:0] m, ref logic ovf);
		if (neg) begin
			if (m > 64'h8000_0000) begin
				ovf = 1;
				return 32'h8000_0000;
			end
			return 32'd0 - m[31:0];
		end
		if (m > 64'h7FFF_FFFF) begin
			ovf = 1;
			return 32'h7FFF_FFFF;
		end
		return m[31:0];
	endfunction

	function automatic logic [63:0] signed_sum(longint p, longint q, bit sub, ref logic neg);
		logic pn, qn;
		logic [63:0] pm, qm;
		pn = p < 0;
		qn = (q < 0) != sub;
		pm = mag(p);
		qm = mag(q);
		if (q == 0) qn = 0;
		if (pn == qn) begin
			neg = pn && (pm + qm != 0);
			return pm + qm;
		end
		if (pm >= qm) begin
			neg = pn && (pm != qm);
			return pm - qm;
		end
		neg = qn;
		return qm - pm;
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] fix_quot(logic [63:0] n, logic [63:0] d, ref logic huge);
		logic [63:0] q, r;
		q = n / d;
		r = n % d;
		if ((q >> (32 - FRAC_BITS)) != 0) begin
			huge = 1;
			return 0;
		end
		for (int i = 0; i <= FRAC_BITS; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= d) begin
				r -= d;
				q |= 1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic logic [31:0] clamp_wide(longint v, ref logic ovf);
		return clamp_mag(v < 0, mag(v), ovf);
	endfunction

	function automatic cplx_res_t complex_result(op_beat_t x);
		cplx_res_t o;
		longint ar, ai, br, bi;
		logic ovf, neg, huge;
		logic [63:0] m, d, half, up, dn, ab;
		ar = longint'(signed'(x.ar));
		ai = longint'(signed'(x.ai));
		br = longint'(signed'(x.br));
		bi = longint'(signed'(x.bi));
		ovf = 0;
		half = 64'd1 << (FRAC_BITS - 1);
		o.re = 0;
		o.im = 0;
		o.st = ST_OK;
		case (x.op)
			CMD_ADD: begin
				o.re = clamp_wide(ar + br, ovf);
				o.im = clamp_wide(ai + bi, ovf);
			end
			CMD_SUB: begin
				o.re = clamp_wide(ar - br, ovf);
				o.im = clamp_wide(ai - bi, ovf);
			end
			CMD_MUL: begin
				m = signed_sum(ar * br, ai * bi, 1, neg);
				o.re = clamp_mag(neg, (m + half) >> FRAC_BITS, ovf);
				m = signed_sum(ar * bi, ai * br, 0, neg);
				o.im = clamp_mag(neg, (m + half) >> FRAC_BITS, ovf);
			end
			CMD_DIV: begin
				d = 64'(br * br) + 64'(bi * bi);
				if (d == 0) o.st = ST_DIVZ;
				else begin
					huge = 0;
					m = signed_sum(ar * br, ai * bi, 0, neg);
					m = fix_quot(m, d, huge);
					o.re = clamp_mag(neg, huge ? 64'd1 << 40 : m, ovf);
					huge = 0;
					m = signed_sum(ai * br, ar * bi, 1, neg);
					m = fix_quot(m, d, huge);
					o.im = clamp_mag(neg, huge ? 64'd1 << 40 : m, ovf);
				end
			end
			CMD_SQRT: begin
				ab = int_root(64'(ar * ar) + 64'(ai * ai));
				up = ab + 64'(ar);
				dn = ab - 64'(ar);
				o.re = clamp_mag(0, int_root(up << (FRAC_BITS - 1)), ovf);
				o.im = clamp_mag(ai < 0, int_root(dn << (FRAC_BITS - 1)), ovf);
			end
			default: ;
		endcase
		if (o.st == ST_OK && ovf) o.st = ST_SAT;
		o.eq = (x.ar == x.br) && (x.ai == x.bi);
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)) << 4;
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0001_0000;
					3: return 32'hFFFF_0000;
					default: return 32'd0;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	task automatic add_op(logic [2:0] op, logic [31:0] ar, ai, br, bi);
		op_beat_t x;
		x.op = op;
		x.ar = ar;
		x.ai = ai;
		x.br = br;
		x.bi = bi;
		pending_ops.push_back(x);
	endtask

	// driver: new beat at the falling edge, random gap per beat
	always @(negedge clk) begin
		if (arst_n && start && !busy) begin
			expected_res.push_back(complex_result(pending_ops.pop_front()));
			n_sent++;
			gap = $urandom_range(0, 18);
			if ($urandom_range(0, 3) == 0) gap = 0;
		end
		if (!arst_n || pending_ops.size() == 0) start <= 1'b0;
		else if (gap > 0 && !(start && !busy && gap == 0)) begin
			start <= 1'b0;
			gap--;
		end else begin
			start <= 1'b1;
			cmd <= pending_ops[0].op;
			a_re <= pending_ops[0].ar;
			a_im <= pending_ops[0].ai;
			b_re <= pending_ops[0].br;
			b_im <= pending_ops[0].bi;
		end
	end

	// monitor
	always @(posedge clk) begin
		cplx_res_t e;
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_res.pop_front();
				n_checked++;
				if (res_re !== e.re) begin
					$error("res_re exp %h got %h", e.re, res_re);
					errors++;
				end
				if (res_im !== e.im) begin
					$error("res_im exp %h got %h", e.im, res_im);
					errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
				if (operands_equal !== e.eq) begin
					$error("operands_equal exp %b got %b", e.eq, operands_equal);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ADD;
		a_re = 0;
		a_im = 0;
		b_re = 0;
		b_im = 0;
		// corners
		add_op(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		add_op(CMD_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000);
		add_op(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		add_op(CMD_SUB, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
		add_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_op(CMD_MUL, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_0001);
		add_op(CMD_MUL, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
		add_op(CMD_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
		add_op(CMD_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
		add_op(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
		add_op(CMD_DIV, 32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0);
		add_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_op(CMD_SQRT, 32'h0004_0000, 32'h0, 32'h0, 32'h0);
		add_op(CMD_SQRT, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0);
		add_op(CMD_SQRT, 32'h0, 32'h0, 32'h0, 32'h0);
		add_op(CMD_SQRT, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h1);
		add_op(CMD_SQRT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
		add_op(CMD_SQRT, 32'h0, 32'hFFFE_0000, 32'h0, 32'h0);
		add_op(3'd5, 32'h1, 32'h2, 32'h1, 32'h2);
		add_op(3'd6, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
		add_op(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		for (int i = 0; i < 1330; i++) begin
			logic [31:0] ar, ai, br, bi;
			ar = rand_operand();
			ai = rand_operand();
			br = rand_operand();
			bi = rand_operand();
			if ($urandom_range(0, 15) == 0) begin
				br = ar;
				bi = ai;
			end
			add_op($urandom_range(0, 7) < 7 ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7)),
				ar, ai, br, bi);
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_ops.size() == 0 && !start);
		wait (expected_res.size() == 0);
		repeat (80) @(posedge clk);
		$display("checked %0d of %0d beats over all operation codes with random gaps",
			n_checked, n_sent);
		if (errors == 0 && expected_res.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: complex_arithmetic_unit.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div.sv
rtl/core/cau_sqrt.sv
rtl/core/complex_arithmetic_unit.sv
tb/tb_complex_arithmetic_unit.sv
